/* src/closest_point_on_triangle_unit_assert.svh */
// ----------------------------------------------------------------------------
// closest point on triangle assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_TRIANGLE_UNIT_ASSERT_SVH
`define CLOSEST_POINT_ON_TRIANGLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CPT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define CPT_ASSERT(lbl, prop, msg)
`define CPT_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* src/cpt_pkg.sv */
// ----------------------------------------------------------------------------
// cpt_pkg
// shared types and width helpers of the closest point on triangle unit
// ----------------------------------------------------------------------------
package cpt_pkg;

  typedef enum logic [2:0] {
    REG_VERT_A  = 3'd0,
    REG_VERT_B  = 3'd1,
    REG_EDGE_AB = 3'd2,
    REG_VERT_C  = 3'd3,
    REG_EDGE_AC = 3'd4,
    REG_EDGE_BC = 3'd5,
    REG_FACE    = 3'd6
  } region_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int MUL_LATENCY = 2;

  // width of a dot product of two coordinate differences, summed over three axes
  function automatic int dot_bits(input int w);
    return 2 * w + 4;
  endfunction

  // numerators and divisors as they leave the front end
  function automatic int num_bits(input int w);
    return 2 * dot_bits(w) + 3;
  endfunction

  function automatic int item_bits(input int w);
    return 3 + 3 * w + 6 * (w + 1) + 4 * num_bits(w);
  endfunction

endpackage

/* src/cpt_stream_if.sv */
// ----------------------------------------------------------------------------
// cpt stream interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface cpt_in_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic signed [W-1:0] point_z;
  logic signed [W-1:0] vert_a_x;
  logic signed [W-1:0] vert_a_y;
  logic signed [W-1:0] vert_a_z;
  logic signed [W-1:0] vert_b_x;
  logic signed [W-1:0] vert_b_y;
  logic signed [W-1:0] vert_b_z;
  logic signed [W-1:0] vert_c_x;
  logic signed [W-1:0] vert_c_y;
  logic signed [W-1:0] vert_c_z;

  modport source (
    output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    output ready
  );
endinterface

interface cpt_out_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] closest_x;
  logic signed [W-1:0] closest_y;
  logic signed [W-1:0] closest_z;
  logic [2:0]          region;

  modport source (output valid, closest_x, closest_y, closest_z, region, input ready);
  modport sink (input valid, closest_x, closest_y, closest_z, region, output ready);
endinterface

/* src/closest_point_on_triangle_unit.sv */
// ----------------------------------------------------------------------------
// closest_point_on_triangle_unit
// closest point on a triangle to a query point, with its Voronoi region
//
//   channel   dir  handshake              payload
//   in_ch     in   valid / ready          point, vertices a b c
//   out_ch    out  valid / ready          closest point, region
//
// one request per cycle sustained while out_ch takes results; a request
// passes the front pipeline, the queue and the back end, whose
// bit-per-stage parameter dividers work on NB = 4*COORD_WIDTH+11 bits
// rst_n clears the valid bits of both pipelines and empties the queue
// a stalled result stalls the back end only; the front end keeps working
// until the queue fills
// ----------------------------------------------------------------------------
`include "closest_point_on_triangle_unit_assert.svh"

module closest_point_on_triangle_unit import cpt_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  cpt_in_if.sink    in_ch,
  cpt_out_if.source out_ch
);

  localparam int IW = item_bits(COORD_WIDTH);

  logic          front_valid;
  logic          q_ready;
  logic [IW-1:0] front_item;
  logic          q_valid;
  logic          back_ready;
  logic [IW-1:0] q_item;

  cpt_front #(.W(COORD_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_valid (front_valid),
    .item_ready (q_ready),
    .item       (front_item)
  );

  cpt_queue #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (q_ready),
    .push_data  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (back_ready),
    .pop_data   (q_item)
  );

  cpt_back #(.W(COORD_WIDTH), .F(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (back_ready),
    .item       (q_item),
    .out_ch     (out_ch)
  );

  `CPT_ASSERT(a_region_code, out_ch.valid |-> out_ch.region <= REG_FACE, "bad region code")
  `CPT_ASSERT_NEXT(a_front_hold, front_valid && !q_ready, front_valid, "front item lost")

endmodule

/* src/cpt_mul.sv */
// ----------------------------------------------------------------------------
// cpt_mul
// two-stage signed multiplier, operands split into 32-bit limbs, limb
// products registered, then shifted and summed
// ----------------------------------------------------------------------------
module cpt_mul #(
  parameter int AW = 34,
  parameter int BW = 34
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int LB = 32;
  localparam int NA = (AW + LB - 1) / LB;
  localparam int NL = (BW + LB - 1) / LB;
  localparam int PW = 2 * LB + 2;

  logic signed [NA*LB-1:0]  ax;
  logic signed [NL*LB-1:0]  bx;
  logic signed [LB:0]       al [NA];
  logic signed [LB:0]       bl [NL];
  logic signed [PW-1:0]     pp_nxt [NA][NL];
  logic signed [PW-1:0]     pp_r [NA][NL];
  logic signed [AW+BW-1:0]  p_r, p_nxt;

  always_comb begin
    ax = (NA*LB)'(a);
    bx = (NL*LB)'(b);
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) begin
        al[i] = (LB+1)'($signed(ax[i*LB +: LB]));
      end else begin
        al[i] = $signed({1'b0, ax[i*LB +: LB]});
      end
    end
    for (int j = 0; j < NL; j++) begin
      if (j == NL - 1) begin
        bl[j] = (LB+1)'($signed(bx[j*LB +: LB]));
      end else begin
        bl[j] = $signed({1'b0, bx[j*LB +: LB]});
      end
    end
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NL; j++) begin
        pp_nxt[i][j] = al[i] * bl[j];
      end
    end
    p_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NL; j++) begin
        p_nxt = p_nxt + ((AW+BW)'(pp_r[i][j]) <<< (LB * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r <= pp_nxt;
      p_r  <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

/* src/cpt_div.sv */
// ----------------------------------------------------------------------------
// cpt_div
// pipelined signed divider, one quotient bit per stage, numerator scaled
// by 2^F, quotient truncated toward zero, zero divisor gives zero
// ----------------------------------------------------------------------------
module cpt_div #(
  parameter int NB = 139,
  parameter int F  = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NB-1:0] num,
  input  logic signed [NB-1:0] den,
  output logic signed [NB+F:0] quo
);

  localparam int NW = NB + F;

  logic [NB-1:0] rem_r [0:NW];
  logic [NB-1:0] rem_nxt [0:NW];
  logic [NW-1:0] nq_r [0:NW];
  logic [NW-1:0] nq_nxt [0:NW];
  logic [NB-1:0] dm_r [0:NW];
  logic [NB:0]   t_w [0:NW];
  logic [NB:0]   ts_w [0:NW];
  logic [NW:0]   ng_r;
  logic [NW:0]   zr_r;
  logic [NB-1:0] nmag;
  logic [NB-1:0] dmag;
  logic signed [NW:0] qq;
  logic signed [NW:0] quo_r, quo_nxt;

  always_comb begin
    nmag = NB'(num[NB-1] ? -num : num);
    dmag = NB'(den[NB-1] ? -den : den);
    rem_nxt[0] = '0;
    nq_nxt[0]  = {nmag, {F{1'b0}}};
    t_w[0]     = '0;
    ts_w[0]    = '0;
    for (int k = 1; k <= NW; k++) begin
      t_w[k]  = {rem_r[k-1], nq_r[k-1][NW-1]};
      ts_w[k] = t_w[k] - {1'b0, dm_r[k-1]};
      if (!ts_w[k][NB]) begin
        rem_nxt[k] = ts_w[k][NB-1:0];
        nq_nxt[k]  = {nq_r[k-1][NW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = t_w[k][NB-1:0];
        nq_nxt[k]  = {nq_r[k-1][NW-2:0], 1'b0};
      end
    end
    qq = $signed({1'b0, nq_r[NW]});
    if (zr_r[NW]) begin
      quo_nxt = '0;
    end else if (ng_r[NW]) begin
      quo_nxt = -qq;
    end else begin
      quo_nxt = qq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= rem_nxt[0];
      nq_r[0]  <= nq_nxt[0];
      dm_r[0]  <= dmag;
      ng_r[0]  <= num[NB-1] ^ den[NB-1];
      zr_r[0]  <= (den == '0);
      for (int k = 1; k <= NW; k++) begin
        rem_r[k] <= rem_nxt[k];
        nq_r[k]  <= nq_nxt[k];
        dm_r[k]  <= dm_r[k-1];
        ng_r[k]  <= ng_r[k-1];
        zr_r[k]  <= zr_r[k-1];
      end
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

/* src/cpt_queue.sv */
// ----------------------------------------------------------------------------
// cpt_queue
// small register queue between front end and back end
// ----------------------------------------------------------------------------
module cpt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             push;
  logic             pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

/* src/cpt_front.sv */
// ----------------------------------------------------------------------------
// cpt_front
// front end: differences, dot products, cross terms and region test,
// packs region, base vertex, divisors, numerators and edge vectors for the back end
// ----------------------------------------------------------------------------
module cpt_front import cpt_pkg::*; #(
  parameter int W = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  cpt_in_if.sink                    in_ch,
  output logic                      item_valid,
  input  logic                      item_ready,
  output logic [item_bits(W)-1:0]   item
);

  localparam int DW = dot_bits(W);
  localparam int VW = 2 * DW + 1;
  localparam int NB = num_bits(W);

  typedef struct packed {
    logic [2:0][W-1:0] a;
    logic [2:0][W-1:0] b;
    logic [2:0][W-1:0] c;
    logic [2:0][W:0]   ab;
    logic [2:0][W:0]   ac;
    logic [2:0][W:0]   bc;
  } geo_t;

  typedef struct packed {
    region_t           region;
    logic [2:0][W-1:0] base;
    logic [2:0][W:0]   ve1;
    logic [2:0][W:0]   ve2;
    logic [NB-1:0]     n1;
    logic [NB-1:0]     n2;
    logic [NB-1:0]     dn1;
    logic [NB-1:0]     dn2;
  } item_t;

  logic [6:0] vld_r;
  logic       fen;

  logic signed [W-1:0]    pp [3];
  logic signed [W-1:0]    pa [3];
  logic signed [W-1:0]    pb [3];
  logic signed [W-1:0]    pc [3];
  geo_t                   geo_nxt;
  geo_t                   geo_r [0:5];
  logic signed [W:0]      pv_nxt [3][3];
  logic signed [W:0]      pv_r [3][3];
  logic signed [2*W+1:0]  pr_nxt [6][3];
  logic signed [2*W+1:0]  pr_r [6][3];
  logic signed [DW-1:0]   d_nxt [6];
  logic signed [DW-1:0]   d_r [2:5][6];
  logic signed [DW-1:0]   mul_a [6];
  logic signed [DW-1:0]   mul_b [6];
  logic signed [2*DW-1:0] cr_w [6];
  logic signed [VW-1:0]   v_nxt [3];
  logic signed [VW-1:0]   v_r [3];
  item_t                  item_nxt;
  item_t                  item_r;

  // classification terms
  logic signed [DW-1:0] d1, d2, d3, d4, d5, d6;
  logic signed [DW:0]   e1, e2;
  logic signed [VW-1:0] va, vb, vc;
  logic                 d1_pos, d2_pos, d3_pos, d6_pos;
  logic                 d1_neg, d2_neg, d3_neg, d6_neg;
  logic                 va_pos, vb_pos, vc_pos;

  assign fen         = !vld_r[6] || item_ready;
  assign in_ch.ready = fen;
  assign item_valid  = vld_r[6];
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (fen) begin
      vld_r <= {vld_r[5:0], in_ch.valid};
    end
  end

  // differences
  always_comb begin
    pp[0] = in_ch.point_x;  pp[1] = in_ch.point_y;  pp[2] = in_ch.point_z;
    pa[0] = in_ch.vert_a_x; pa[1] = in_ch.vert_a_y; pa[2] = in_ch.vert_a_z;
    pb[0] = in_ch.vert_b_x; pb[1] = in_ch.vert_b_y; pb[2] = in_ch.vert_b_z;
    pc[0] = in_ch.vert_c_x; pc[1] = in_ch.vert_c_y; pc[2] = in_ch.vert_c_z;
    for (int k = 0; k < 3; k++) begin
      geo_nxt.a[k]  = pa[k];
      geo_nxt.b[k]  = pb[k];
      geo_nxt.c[k]  = pc[k];
      geo_nxt.ab[k] = (W+1)'(pb[k]) - (W+1)'(pa[k]);
      geo_nxt.ac[k] = (W+1)'(pc[k]) - (W+1)'(pa[k]);
      geo_nxt.bc[k] = (W+1)'(pc[k]) - (W+1)'(pb[k]);
      pv_nxt[0][k]  = (W+1)'(pp[k]) - (W+1)'(pa[k]);
      pv_nxt[1][k]  = (W+1)'(pp[k]) - (W+1)'(pb[k]);
      pv_nxt[2][k]  = (W+1)'(pp[k]) - (W+1)'(pc[k]);
    end
  end

  // per-axis products, d1 d3 d5 use ab and d2 d4 d6 use ac
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      for (int k = 0; k < 3; k++) begin
        if (j % 2 == 0) begin
          pr_nxt[j][k] = $signed(geo_r[0].ab[k]) * pv_r[j/2][k];
        end else begin
          pr_nxt[j][k] = $signed(geo_r[0].ac[k]) * pv_r[j/2][k];
        end
      end
    end
    for (int j = 0; j < 6; j++) begin
      d_nxt[j] = DW'(pr_r[j][0]) + DW'(pr_r[j][1]) + DW'(pr_r[j][2]);
    end
  end

  // cross terms d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
  always_comb begin
    mul_a[0] = d_r[2][0]; mul_b[0] = d_r[2][3];
    mul_a[1] = d_r[2][2]; mul_b[1] = d_r[2][1];
    mul_a[2] = d_r[2][4]; mul_b[2] = d_r[2][1];
    mul_a[3] = d_r[2][0]; mul_b[3] = d_r[2][5];
    mul_a[4] = d_r[2][2]; mul_b[4] = d_r[2][5];
    mul_a[5] = d_r[2][4]; mul_b[5] = d_r[2][3];
  end

  for (genvar g = 0; g < 6; g++) begin : g_cross
    cpt_mul #(.AW(DW), .BW(DW)) u_mul (
      .clk (clk),
      .en  (fen),
      .a   (mul_a[g]),
      .b   (mul_b[g]),
      .p   (cr_w[g])
    );
  end

  always_comb begin
    v_nxt[2] = VW'(cr_w[0]) - VW'(cr_w[1]);
    v_nxt[1] = VW'(cr_w[2]) - VW'(cr_w[3]);
    v_nxt[0] = VW'(cr_w[4]) - VW'(cr_w[5]);
  end

  // region test and item packing
  always_comb begin
    d1 = d_r[5][0]; d2 = d_r[5][1]; d3 = d_r[5][2];
    d4 = d_r[5][3]; d5 = d_r[5][4]; d6 = d_r[5][5];
    va = v_r[0];    vb = v_r[1];    vc = v_r[2];
    e1 = (DW+1)'(d4) - (DW+1)'(d3);
    e2 = (DW+1)'(d5) - (DW+1)'(d6);
    d1_neg = d1[DW-1]; d1_pos = !d1[DW-1] && (d1 != '0);
    d2_neg = d2[DW-1]; d2_pos = !d2[DW-1] && (d2 != '0);
    d3_neg = d3[DW-1]; d3_pos = !d3[DW-1] && (d3 != '0);
    d6_neg = d6[DW-1]; d6_pos = !d6[DW-1] && (d6 != '0);
    va_pos = !va[VW-1] && (va != '0);
    vb_pos = !vb[VW-1] && (vb != '0);
    vc_pos = !vc[VW-1] && (vc != '0);

    item_nxt.region = REG_VERT_A;
    item_nxt.base   = geo_r[5].a;
    item_nxt.ve1    = geo_r[5].ab;
    item_nxt.ve2    = geo_r[5].ac;
    item_nxt.n1     = '0;
    item_nxt.n2     = '0;
    item_nxt.dn1    = '0;
    item_nxt.dn2    = '0;
    if (!d1_pos && !d2_pos) begin
      item_nxt.region = REG_VERT_A;
    end else if (!d3_neg && (d4 <= d3)) begin
      item_nxt.region = REG_VERT_B;
      item_nxt.base   = geo_r[5].b;
    end else if (!vc_pos && !d1_neg && !d3_pos) begin
      item_nxt.region = REG_EDGE_AB;
      item_nxt.n1     = NB'(d1);
      item_nxt.dn1    = NB'(d1) - NB'(d3);
    end else if (!d6_neg && (d5 <= d6)) begin
      item_nxt.region = REG_VERT_C;
      item_nxt.base   = geo_r[5].c;
    end else if (!vb_pos && !d2_neg && !d6_pos) begin
      item_nxt.region = REG_EDGE_AC;
      item_nxt.ve1    = geo_r[5].ac;
      item_nxt.n1     = NB'(d2);
      item_nxt.dn1    = NB'(d2) - NB'(d6);
    end else if (!va_pos && !e1[DW] && !e2[DW]) begin
      item_nxt.region = REG_EDGE_BC;
      item_nxt.base   = geo_r[5].b;
      item_nxt.ve1    = geo_r[5].bc;
      item_nxt.n1     = NB'(e1);
      item_nxt.dn1    = NB'(e1) + NB'(e2);
    end else begin
      item_nxt.region = REG_FACE;
      item_nxt.n1     = NB'(vb);
      item_nxt.n2     = NB'(vc);
      item_nxt.dn1    = NB'(va) + NB'(vb) + NB'(vc);
      item_nxt.dn2    = NB'(va) + NB'(vb) + NB'(vc);
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      geo_r[0] <= geo_nxt;
      for (int s = 1; s < 6; s++) begin
        geo_r[s] <= geo_r[s-1];
      end
      pv_r     <= pv_nxt;
      pr_r     <= pr_nxt;
      d_r[2]   <= d_nxt;
      d_r[3]   <= d_r[2];
      d_r[4]   <= d_r[3];
      d_r[5]   <= d_r[4];
      v_r      <= v_nxt;
      item_r   <= item_nxt;
    end
  end

endmodule

/* src/cpt_back.sv */
// ----------------------------------------------------------------------------
// cpt_back
// back end: two parameter divisions, scaling of the edge vectors,
// truncation, offset from the base vertex and saturation
// ----------------------------------------------------------------------------
module cpt_back import cpt_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  logic [item_bits(W)-1:0] item,
  cpt_out_if.source               out_ch
);

  localparam int NB = num_bits(W);
  localparam int NW = NB + F;
  localparam int QW = NW + 1;
  localparam int DL = NW + 2;
  localparam int SL = DL + MUL_LATENCY;
  localparam int MW = W + 1 + QW;
  localparam int PW = MW + 1;
  localparam int TW = PW - F;
  localparam int XW = TW + 1;
  localparam int L  = SL + 2;

  typedef struct packed {
    region_t           region;
    logic [2:0][W-1:0] base;
    logic [2:0][W:0]   ve1;
    logic [2:0][W:0]   ve2;
    logic [NB-1:0]     n1;
    logic [NB-1:0]     n2;
    logic [NB-1:0]     dn1;
    logic [NB-1:0]     dn2;
  } item_t;

  typedef struct packed {
    region_t           region;
    logic [2:0][W-1:0] base;
    logic [2:0][W:0]   ve1;
    logic [2:0][W:0]   ve2;
  } side_t;

  item_t                it;
  side_t                side_nxt;
  side_t                side_r [0:SL-1];
  logic [L-1:0]         vld_r;
  logic                 ben;
  logic signed [QW-1:0] q1, q2;
  logic signed [MW-1:0] m1 [3];
  logic signed [MW-1:0] m2 [3];
  logic signed [PW-1:0] s_w [3];
  logic signed [PW-1:0] sb_w [3];
  logic signed [TW-1:0] tr_nxt [3];
  logic signed [TW-1:0] tr_r [3];
  logic [2:0][W-1:0]    sb_base_r;
  region_t              sb_reg_r;
  logic signed [XW-1:0] x_w [3];
  logic signed [W-1:0]  cx_nxt [3];
  logic signed [W-1:0]  cx_r [3];
  region_t              reg_r;

  assign it         = item_t'(item);
  assign ben        = !vld_r[L-1] || out_ch.ready;
  assign item_ready = ben;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ben) begin
      vld_r <= {vld_r[L-2:0], item_valid};
    end
  end

  always_comb begin
    side_nxt.region = it.region;
    side_nxt.base   = it.base;
    side_nxt.ve1    = it.ve1;
    side_nxt.ve2    = it.ve2;
  end

  cpt_div #(.NB(NB), .F(F)) u_div1 (
    .clk (clk),
    .en  (ben),
    .num (it.n1),
    .den (it.dn1),
    .quo (q1)
  );

  cpt_div #(.NB(NB), .F(F)) u_div2 (
    .clk (clk),
    .en  (ben),
    .num (it.n2),
    .den (it.dn2),
    .quo (q2)
  );

  for (genvar k = 0; k < 3; k++) begin : g_axis
    cpt_mul #(.AW(W + 1), .BW(QW)) u_mul1 (
      .clk (clk),
      .en  (ben),
      .a   ($signed(side_r[DL-1].ve1[k])),
      .b   (q1),
      .p   (m1[k])
    );
    cpt_mul #(.AW(W + 1), .BW(QW)) u_mul2 (
      .clk (clk),
      .en  (ben),
      .a   ($signed(side_r[DL-1].ve2[k])),
      .b   (q2),
      .p   (m2[k])
    );
  end

  // truncate toward zero, then offset and saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s_w[k]  = PW'(m1[k]) + PW'(m2[k]);
      sb_w[k] = s_w[k][PW-1] ? s_w[k] + PW'((2 ** F) - 1) : s_w[k];
      tr_nxt[k] = sb_w[k][PW-1:F];
      x_w[k] = XW'($signed(sb_base_r[k])) + XW'(tr_r[k]);
      if (x_w[k][XW-1:W-1] != {(XW - W + 1){x_w[k][XW-1]}}) begin
        cx_nxt[k] = x_w[k][XW-1] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
      end else begin
        cx_nxt[k] = x_w[k][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      side_r[0] <= side_nxt;
      for (int s = 1; s < SL; s++) begin
        side_r[s] <= side_r[s-1];
      end
      tr_r      <= tr_nxt;
      sb_base_r <= side_r[SL-1].base;
      sb_reg_r  <= side_r[SL-1].region;
      cx_r      <= cx_nxt;
      reg_r     <= sb_reg_r;
    end
  end

  assign out_ch.valid     = vld_r[L-1];
  assign out_ch.closest_x = cx_r[0];
  assign out_ch.closest_y = cx_r[1];
  assign out_ch.closest_z = cx_r[2];
  assign out_ch.region    = reg_r;

endmodule
